FILE: hw/rtl/jdp_pkg.sv
package jdp_pkg;

	// angle pipeline
	localparam int CORDIC_STAGES = 16;
	localparam int TABLE_LEN     = 24;
	localparam int NUM_STAGES    = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
	localparam int STAGE_W       = $clog2(TABLE_LEN);
	localparam int CW            = 36;   // x/y datapath, axis scaled by 2^16 plus gain headroom
	localparam int ZW            = 32;   // degrees, Q.20
	localparam int AXIS_SH       = 16;
	localparam int ROUND_SH      = 13;   // Q.20 -> Q.7

	localparam logic signed [ZW-1:0] DEG90_Q20  = 32'sd94371840;
	localparam logic signed [ZW-1:0] ROUND_HALF = 32'sd4096;
	localparam logic signed [15:0]   ANGLE_LIMIT = 16'sd23040;
	localparam logic signed [15:0]   DEG180_Q7   = 16'sd23040;
	localparam logic signed [15:0]   DEG90_Q7    = 16'sd11520;

	// magnitude pipeline
	localparam int SQRT_BITS  = 32;
	localparam int RAD_W      = 2 * SQRT_BITS;
	localparam int REM_W      = SQRT_BITS + 3;
	localparam int NORM_SHIFT = 31;      // sum of squares * 2^31
	localparam int DIV_SH     = 15;      // divisor is 2^15 - 1
	localparam logic [15:0] NORM_DIV  = 16'd32767;
	localparam logic [15:0] MAG_FULL  = 16'd32768;

	localparam logic [15:0] CENTER_LIM_RST = 16'd8000;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
	} cordic_t;

	typedef struct packed {
		logic [RAD_W-1:0]     rad;
		logic [REM_W-1:0]     rem;
		logic [SQRT_BITS-1:0] root;
	} sqrt_t;

	// atan(2^-i) in degrees, Q.20
	function automatic logic signed [ZW-1:0] atan_q20(input logic [STAGE_W-1:0] idx);
		logic signed [ZW-1:0] v;
		case (idx)
			5'd0:    v = 32'sd47185920;
			5'd1:    v = 32'sd27855475;
			5'd2:    v = 32'sd14718068;
			5'd3:    v = 32'sd7471121;
			5'd4:    v = 32'sd3750058;
			5'd5:    v = 32'sd1876857;
			5'd6:    v = 32'sd938658;
			5'd7:    v = 32'sd469357;
			5'd8:    v = 32'sd234682;
			5'd9:    v = 32'sd117342;
			5'd10:   v = 32'sd58671;
			5'd11:   v = 32'sd29335;
			5'd12:   v = 32'sd14668;
			5'd13:   v = 32'sd7334;
			5'd14:   v = 32'sd3667;
			5'd15:   v = 32'sd1833;
			5'd16:   v = 32'sd917;
			5'd17:   v = 32'sd458;
			5'd18:   v = 32'sd229;
			5'd19:   v = 32'sd115;
			5'd20:   v = 32'sd57;
			5'd21:   v = 32'sd29;
			5'd22:   v = 32'sd14;
			5'd23:   v = 32'sd7;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

FILE: hw/rtl/jdp_sqrt_cell.sv
// One root bit per cell, restoring method: radicand shifts out two bits a cell.
module jdp_sqrt_cell (
	input  logic            clk,
	input  logic            en,
	input  jdp_pkg::sqrt_t  d,
	output jdp_pkg::sqrt_t  q
);

	logic [jdp_pkg::REM_W-1:0] rem_sh;
	logic [jdp_pkg::REM_W-1:0] trial;
	logic                      ge;
	jdp_pkg::sqrt_t            nxt;

	always_comb begin
		rem_sh   = {d.rem[jdp_pkg::REM_W-3:0], d.rad[jdp_pkg::RAD_W-1 -: 2]};
		trial    = {1'b0, d.root, 2'b01};
		ge       = (rem_sh >= trial);
		nxt.rad  = {d.rad[jdp_pkg::RAD_W-3:0], 2'b00};
		nxt.rem  = ge ? (rem_sh - trial) : rem_sh;
		nxt.root = {d.root[jdp_pkg::SQRT_BITS-2:0], ge};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

FILE: hw/rtl/jdp_cordic_cell.sv
// One vectoring micro-rotation; stage number picks shift and angle step.
module jdp_cordic_cell (
	input  logic                         clk,
	input  logic                         en,
	input  logic [jdp_pkg::STAGE_W-1:0]  stage_idx,
	input  jdp_pkg::cordic_t             d,
	output jdp_pkg::cordic_t             q
);

	logic signed [jdp_pkg::CW-1:0] xi;
	logic signed [jdp_pkg::CW-1:0] yi;
	logic signed [jdp_pkg::CW-1:0] dx;
	logic signed [jdp_pkg::CW-1:0] dy;
	logic signed [jdp_pkg::ZW-1:0] step;
	jdp_pkg::cordic_t              nxt;

	always_comb begin
		xi   = d.x;
		yi   = d.y;
		dx   = yi >>> stage_idx;   // floor shift
		dy   = xi >>> stage_idx;
		step = jdp_pkg::atan_q20(stage_idx);
		if (!yi[jdp_pkg::CW-1]) begin
			nxt.x = xi + dx;
			nxt.y = yi - dy;
			nxt.z = d.z + step;
		end else begin
			nxt.x = xi - dx;
			nxt.y = yi + dy;
			nxt.z = d.z - step;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

FILE: hw/rtl/joystick_deadzone_polar.sv
// Stick sample to polar form with dead zone. One x/y beat per clock is taken
// while in_stall is low, and each beat yields exactly one result beat after
// the front register, squares, sum, the 32-cell square-root chain behind the
// magnitude, quotient estimate, quotient correction and output register. The
// angle runs in a parallel CORDIC chain of CORDIC_STAGES cells and is delayed
// to meet the magnitude. The whole pipe moves as one: it freezes only while a
// result sits in the output register and out_stall is high, so in_stall is
// high exactly then. magnitude is round(|v| / (32767*sqrt 2)) in Q1.15 from
// the raw axes, saturating at 1.0. If both |x| and |y| are below the
// dead-zone threshold, x_out, y_out and angle are zero and in_dead_zone is
// set; else angle is atan2(-y, x) in degrees, Q9.7, with the axis directions
// exact. The threshold resets to 8000; the user must write it only while the
// pipe is empty, through cfg_wr_en / cfg_wr_data; the block does not check.
module joystick_deadzone_polar (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [15:0]        cfg_wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] x_axis,
	input  logic signed [15:0] y_axis,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] x_out,
	output logic signed [15:0] y_out,
	output logic [15:0]        magnitude,
	output logic signed [15:0] angle,
	output logic               in_dead_zone
);

	// pipe depth: 3 front stages, root cells, 3 finishing stages
	localparam int LAT      = jdp_pkg::SQRT_BITS + 6;
	// angle rounding sits right after the last CORDIC cell, the line ends at LAT-1
	localparam int ANG_LAST = LAT - 4 - jdp_pkg::NUM_STAGES;
	localparam int QW       = jdp_pkg::SQRT_BITS - jdp_pkg::DIV_SH + 1;

	// fields that ride alongside the math
	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic               dz;
		logic               spec;      // point on an axis: angle is exact
		logic signed [15:0] spec_ang;
	} side_t;

	typedef struct packed {
		logic signed [16:0] px;
		logic signed [16:0] py;        // -y, up is positive
		logic [16:0]        ax;
		logic [16:0]        ay;
	} front_t;

	logic [15:0] center_lim_q;
	logic        adv;
	logic [1:LAT] vld_q;

	// stage 1 front
	logic signed [16:0] xe, ye, ny;
	logic [16:0]        ax, ay;
	logic               centered;
	side_t              side_d;
	front_t             front_d;
	front_t             front_s1;
	side_t              side_q [1:LAT-1];

	// stage 2
	logic [33:0]            ax_prod, ay_prod;
	logic [30:0]            ax2_s2, ay2_s2;
	logic signed [jdp_pkg::CW-1:0] xs, ys;
	jdp_pkg::cordic_t       rot_d;
	jdp_pkg::cordic_t       rot_s2;

	// stage 3 and root chain
	logic [31:0]            sumsq;
	jdp_pkg::sqrt_t         rad_s3;
	jdp_pkg::sqrt_t         sqrt_w [1:jdp_pkg::SQRT_BITS];
	jdp_pkg::sqrt_t         sqrt_in [0:jdp_pkg::SQRT_BITS-1];
	jdp_pkg::cordic_t       cordic_w [0:jdp_pkg::NUM_STAGES];

	// finishing stages
	logic [jdp_pkg::SQRT_BITS-1:0] root;
	logic [jdp_pkg::SQRT_BITS:0]   est_sum;
	logic [jdp_pkg::SQRT_BITS-1:0] root_s36;
	logic [QW-1:0]                 quo_s36;
	logic [jdp_pkg::SQRT_BITS+1:0] rem_chk;
	logic [QW-1:0]                 quo_s37;
	logic [QW:0]                   half;
	logic [15:0]                   mag_d;

	// angle rounding and delay line
	logic signed [jdp_pkg::ZW:0]   z_rnd;
	logic signed [jdp_pkg::ZW:0]   z_sh;
	logic signed [15:0]            ang_d;
	logic signed [15:0]            ang_q [0:ANG_LAST];
	logic signed [15:0]            ang_out;

	// whole pipe holds only when the output beat is refused
	assign adv      = !(vld_q[LAT] && out_stall);
	assign in_stall = !adv;
	assign out_valid = vld_q[LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_lim_q <= jdp_pkg::CENTER_LIM_RST;
		end else if (cfg_wr_en) begin
			center_lim_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {in_valid, vld_q[1:LAT-1]};
		end
	end

	// front: abs, dead zone, axis special cases
	always_comb begin
		xe       = 17'(x_axis);
		ye       = 17'(y_axis);
		ny       = -ye;
		ax       = 17'(xe[16] ? -xe : xe);
		ay       = 17'(ye[16] ? -ye : ye);
		centered = (ax < {1'b0, center_lim_q}) && (ay < {1'b0, center_lim_q});

		side_d.dz       = centered;
		side_d.x        = centered ? 16'sd0 : x_axis;
		side_d.y        = centered ? 16'sd0 : y_axis;
		side_d.spec     = (x_axis == 16'sd0) || (y_axis == 16'sd0);
		side_d.spec_ang = 16'sd0;
		if (y_axis == 16'sd0) begin
			// origin and positive x give zero
			if (x_axis[15]) begin
				side_d.spec_ang = jdp_pkg::DEG180_Q7;
			end
		end else if (x_axis == 16'sd0) begin
			side_d.spec_ang = y_axis[15] ? jdp_pkg::DEG90_Q7 : -jdp_pkg::DEG90_Q7;
		end

		front_d.px = xe;
		front_d.py = ny;
		front_d.ax = ax;
		front_d.ay = ay;
	end

	// pre-rotation into the right half plane
	always_comb begin
		xs = jdp_pkg::CW'(front_s1.px);
		ys = jdp_pkg::CW'(front_s1.py);
		xs = xs <<< jdp_pkg::AXIS_SH;
		ys = ys <<< jdp_pkg::AXIS_SH;
		rot_d.x = xs;
		rot_d.y = ys;
		rot_d.z = '0;
		if (xs[jdp_pkg::CW-1]) begin
			if (!ys[jdp_pkg::CW-1]) begin
				rot_d.x = ys;
				rot_d.y = -xs;
				rot_d.z = jdp_pkg::DEG90_Q20;
			end else begin
				rot_d.x = -ys;
				rot_d.y = xs;
				rot_d.z = -jdp_pkg::DEG90_Q20;
			end
		end
		ax_prod = front_s1.ax * front_s1.ax;
		ay_prod = front_s1.ay * front_s1.ay;
	end

	always_comb begin
		sumsq = 32'(ax2_s2) + 32'(ay2_s2);
	end

	// magnitude finish: q0 = floor estimate of root / 32767, at most one short
	always_comb begin
		root    = sqrt_w[jdp_pkg::SQRT_BITS].root;
		est_sum = (jdp_pkg::SQRT_BITS+1)'(root)
			+ (jdp_pkg::SQRT_BITS+1)'(root >> jdp_pkg::DIV_SH)
			+ (jdp_pkg::SQRT_BITS+1)'(root >> (2 * jdp_pkg::DIV_SH));
		rem_chk = (jdp_pkg::SQRT_BITS+2)'(root_s36) + (jdp_pkg::SQRT_BITS+2)'(quo_s36)
			- ((jdp_pkg::SQRT_BITS+2)'(quo_s36) << jdp_pkg::DIV_SH);
		half    = ((QW+1)'(quo_s37) + (QW+1)'(1)) >> 1;
		mag_d   = (half >= (QW+1)'(jdp_pkg::MAG_FULL)) ? jdp_pkg::MAG_FULL : half[15:0];
	end

	// angle: round Q.20 to Q.7 and clamp; dead zone and axis beats override it
	always_comb begin
		z_rnd = (jdp_pkg::ZW+1)'(cordic_w[jdp_pkg::NUM_STAGES].z)
			+ (jdp_pkg::ZW+1)'(jdp_pkg::ROUND_HALF);
		z_sh  = z_rnd >>> jdp_pkg::ROUND_SH;
		if (z_sh > jdp_pkg::ANGLE_LIMIT) begin
			ang_d = jdp_pkg::ANGLE_LIMIT;
		end else if (z_sh < -jdp_pkg::ANGLE_LIMIT) begin
			ang_d = -jdp_pkg::ANGLE_LIMIT;
		end else begin
			ang_d = 16'(z_sh);
		end
		if (side_q[LAT-1].dz) begin
			ang_out = 16'sd0;
		end else if (side_q[LAT-1].spec) begin
			ang_out = side_q[LAT-1].spec_ang;
		end else begin
			ang_out = ang_q[ANG_LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			front_s1   <= front_d;
			side_q[1]  <= side_d;
			for (int i = 2; i < LAT; i++) begin
				side_q[i] <= side_q[i-1];
			end

			ax2_s2     <= ax_prod[30:0];
			ay2_s2     <= ay_prod[30:0];
			rot_s2     <= rot_d;

			rad_s3.rad  <= jdp_pkg::RAD_W'({sumsq, {jdp_pkg::NORM_SHIFT{1'b0}}});
			rad_s3.rem  <= '0;
			rad_s3.root <= '0;

			root_s36 <= root;
			quo_s36  <= QW'(est_sum >> jdp_pkg::DIV_SH);
			quo_s37  <= quo_s36
				+ QW'(rem_chk >= (jdp_pkg::SQRT_BITS+2)'(jdp_pkg::NORM_DIV));

			ang_q[0] <= ang_d;
			for (int k = 1; k <= ANG_LAST; k++) begin
				ang_q[k] <= ang_q[k-1];
			end

			x_out        <= side_q[LAT-1].x;
			y_out        <= side_q[LAT-1].y;
			in_dead_zone <= side_q[LAT-1].dz;
			magnitude    <= mag_d;
			angle        <= ang_out;
		end
	end

	// root chain
	assign sqrt_in[0] = rad_s3;
	for (genvar g = 1; g < jdp_pkg::SQRT_BITS; g++) begin : g_sqrt_link
		assign sqrt_in[g] = sqrt_w[g];
	end

	for (genvar g = 0; g < jdp_pkg::SQRT_BITS; g++) begin : g_sqrt
		jdp_sqrt_cell u_cell (
			.clk (clk),
			.en  (adv),
			.d   (sqrt_in[g]),
			.q   (sqrt_w[g+1])
		);
	end

	// CORDIC chain
	assign cordic_w[0] = rot_s2;
	for (genvar g = 0; g < jdp_pkg::NUM_STAGES; g++) begin : g_cordic
		jdp_cordic_cell u_cell (
			.clk       (clk),
			.en        (adv),
			.stage_idx (jdp_pkg::STAGE_W'(g)),
			.d         (cordic_w[g]),
			.q         (cordic_w[g+1])
		);
	end

	// centered beats carry no direction
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && in_dead_zone |-> x_out == 16'sd0 && y_out == 16'sd0 && angle == 16'sd0)
		else $error("dead zone beat with nonzero axes or angle");

	a_mag_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> magnitude <= jdp_pkg::MAG_FULL)
		else $error("magnitude above 1.0");

	a_ang_rng: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> angle <= jdp_pkg::ANGLE_LIMIT && angle >= -jdp_pkg::ANGLE_LIMIT)
		else $error("angle out of range");

	a_neg_x: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_dead_zone && y_out == 16'sd0 && x_out[15]
		|-> angle == jdp_pkg::DEG180_Q7)
		else $error("negative x axis not at 180 degrees");

endmodule
